// ===== sv/xld_pkg.sv =====
// ----------------------------------------------------------------------------
// xld_pkg
// Shared types, status codes and the character alphabet for the line decoder.
// ----------------------------------------------------------------------------
package xld_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned SEXTET_W = 6;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned HOLD_W   = 3 * SEXTET_W;
  localparam int unsigned STATUS_W = 4;

  // largest byte count that a line may declare
  localparam logic [LEN_W-1:0] MAX_LINE_BYTES = 6'd45;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // line status codes
  localparam logic [STATUS_W-1:0] ST_PENDING   = 4'd0;
  localparam logic [STATUS_W-1:0] ST_PAYLOAD   = 4'd1;
  localparam logic [STATUS_W-1:0] ST_TERM      = 4'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd3;
  localparam logic [STATUS_W-1:0] ST_BADCHAR   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_TOOMANY   = 4'd5;
  localparam logic [STATUS_W-1:0] ST_TRUNC     = 4'd6;
  localparam logic [STATUS_W-1:0] ST_TRAILING  = 4'd7;
  localparam logic [STATUS_W-1:0] ST_TERMTRAIL = 4'd8;

  typedef enum logic [2:0] {
    PH_LEN  = 3'd0,
    PH_PAY  = 3'd1,
    PH_TAIL = 3'd2,
    PH_TERM = 3'd3,
    PH_DEAD = 3'd4
  } phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              char_present;
    logic              line_end;
  } xld_item_t;

  typedef struct packed {
    logic [7:0]          byte_a;
    logic [7:0]          byte_b;
    logic [7:0]          byte_c;
    logic [1:0]          byte_count;
    logic                line_done;
    logic [STATUS_W-1:0] line_status;
  } xld_result_t;

  // alphabet index in the low six bits, bit 6 set when not in the alphabet
  function automatic logic [SEXTET_W:0] sextet_of(input logic [CHAR_W-1:0] c);
    logic [SEXTET_W:0] r;
    r = 7'd64;
    if (c == CH_PLUS) begin
      r = 7'd0;
    end else if (c == CH_MINUS) begin
      r = 7'd1;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = 7'(c - 8'h30 + 8'd2);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r = 7'(c - 8'h41 + 8'd12);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = 7'(c - 8'h61 + 8'd38);
    end
    return r;
  endfunction

endpackage

// ===== sv/xld_line_ctl.sv =====
// ----------------------------------------------------------------------------
// xld_line_ctl
// Per-line state and the decode of one character into a result.
// ----------------------------------------------------------------------------
module xld_line_ctl
  import xld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  xld_item_t   item,
  output xld_result_t result
);

  phase_t              phase_r, phase_nxt, phase_upd;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [1:0]          taken_r, taken_nxt;
  logic [HOLD_W-1:0]   hold_r, hold_nxt;
  logic [LEN_W-1:0]    emitted_r, emitted_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt, err_upd;

  logic [SEXTET_W:0]   sx;
  logic                bad;
  logic [SEXTET_W-1:0] v;
  logic                blank;
  logic [LEN_W-1:0]    left;
  logic [1:0]          take;
  logic [LEN_W-1:0]    emitted_sum;
  logic                grp_done;
  logic                closing;

  assign sx    = sextet_of(item.char_code);
  assign bad   = sx[SEXTET_W];
  assign v     = sx[SEXTET_W-1:0];
  assign blank = (item.char_code == CH_SPACE) || (item.char_code == CH_TAB);
  // in payload phase fewer bytes have been emitted than declared
  assign left        = len_r - emitted_r;
  assign take        = (left < 6'd3) ? left[1:0] : 2'd3;
  assign emitted_sum = emitted_r + LEN_W'(take);
  assign closing     = step && item.line_end;

  // next state
  always_comb begin
    phase_upd   = phase_r;
    len_nxt     = len_r;
    taken_nxt   = taken_r;
    hold_nxt    = hold_r;
    emitted_nxt = emitted_r;
    err_upd     = err_r;
    grp_done    = 1'b0;
    if (step && item.char_present) begin
      case (phase_r)
        PH_LEN: begin
          if (item.char_code == CH_SPACE || sx == 7'd0) begin
            phase_upd = PH_TERM;
          end else if (bad) begin
            phase_upd = PH_DEAD;
            err_upd   = ST_BADCHAR;
          end else if (v > MAX_LINE_BYTES) begin
            phase_upd = PH_DEAD;
            err_upd   = ST_TOOMANY;
          end else begin
            phase_upd   = PH_PAY;
            len_nxt     = v;
            taken_nxt   = 2'd0;
            hold_nxt    = '0;
            emitted_nxt = '0;
          end
        end
        PH_PAY: begin
          if (bad) begin
            err_upd = ST_BADCHAR;
          end
          if (taken_r != 2'd3) begin
            hold_nxt  = {hold_r[HOLD_W-SEXTET_W-1:0], v};
            taken_nxt = taken_r + 2'd1;
          end else begin
            grp_done    = 1'b1;
            emitted_nxt = emitted_sum;
            taken_nxt   = 2'd0;
            hold_nxt    = '0;
            if (emitted_sum >= len_r) begin
              phase_upd = PH_TAIL;
            end
          end
        end
        PH_TAIL: begin
          if (!blank) begin
            err_upd = ST_TRAILING;
          end
        end
        PH_TERM: begin
          if (!blank) begin
            err_upd = ST_TERMTRAIL;
          end
        end
        default: begin
        end
      endcase
    end
    err_nxt   = err_upd;
    phase_nxt = phase_upd;
    // line end returns everything to the start-of-line state
    if (closing) begin
      phase_nxt   = PH_LEN;
      len_nxt     = '0;
      taken_nxt   = 2'd0;
      hold_nxt    = '0;
      emitted_nxt = '0;
      err_nxt     = ST_PENDING;
    end
  end

  // result
  always_comb begin
    result = '0;
    if (grp_done && err_upd == ST_PENDING) begin
      result.byte_a     = {hold_r[17:12], hold_r[11:10]};
      result.byte_count = take;
      if (take > 2'd1) begin
        result.byte_b = {hold_r[9:6], hold_r[5:2]};
      end
      if (take > 2'd2) begin
        result.byte_c = {hold_r[1:0], v};
      end
    end
    if (closing) begin
      result.line_done = 1'b1;
      case (phase_upd)
        PH_LEN:  result.line_status = ST_EMPTY;
        PH_PAY:  result.line_status = ST_TRUNC;
        PH_TAIL: result.line_status = (err_upd != ST_PENDING) ? err_upd : ST_PAYLOAD;
        PH_TERM: result.line_status = (err_upd != ST_PENDING) ? err_upd : ST_TERM;
        default: result.line_status = err_upd;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEN;
      len_r     <= '0;
      taken_r   <= 2'd0;
      hold_r    <= '0;
      emitted_r <= '0;
      err_r     <= ST_PENDING;
    end else begin
      phase_r   <= phase_nxt;
      len_r     <= len_nxt;
      taken_r   <= taken_nxt;
      hold_r    <= hold_nxt;
      emitted_r <= emitted_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

// ===== sv/xxencode_line_decoder.sv =====
// ----------------------------------------------------------------------------
// xxencode_line_decoder
// Streaming decoder for one XXEncoded text line, one character per request.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one character (or a bare line end) per request;
//   in_line_end marks the last request of a line. Every input request yields
//   exactly one out_ request: up to three decoded bytes when a group of four
//   payload characters completes, and the line status on the line-end request.
//   Bytes leave before the status is known, so a consumer drops the bytes of
//   a line whose final status is an error.
//   A request passes the input register, then the result register.
//   Throughput is one request per cycle unless out_stall holds a result; the
//   line state is updated in the single decode stage between the two registers.
//   Reset clears the line state and both stage valids; the next character is
//   taken as a length character.
//   When out_stall holds a waiting result, the whole pipe freezes and in_stall
//   rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module xxencode_line_decoder
  import xld_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CHAR_W-1:0]   in_char_code,
  input  logic                in_char_present,
  input  logic                in_line_end,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte_a,
  output logic [7:0]          out_byte_b,
  output logic [7:0]          out_byte_c,
  output logic [1:0]          out_byte_count,
  output logic                out_line_done,
  output logic [STATUS_W-1:0] out_line_status
);

  logic        advance;
  logic        s1_valid_r;
  xld_item_t   s1_item_r;
  logic        out_valid_r;
  xld_result_t out_res_r;
  xld_result_t res;

  // pipe moves unless a result sits stalled at the output
  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;

  xld_line_ctl u_ctl (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_valid_r && advance),
    .item   (s1_item_r),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item_r <= '{char_code: in_char_code, char_present: in_char_present,
                     line_end: in_line_end};
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_a      = out_res_r.byte_a;
  assign out_byte_b      = out_res_r.byte_b;
  assign out_byte_c      = out_res_r.byte_c;
  assign out_byte_count  = out_res_r.byte_count;
  assign out_line_done   = out_res_r.line_done;
  assign out_line_status = out_res_r.line_status;

endmodule

// ===== sv/xld_checker.sv =====
// ----------------------------------------------------------------------------
// xld_checker
// Port-level checks on the line decoder, attached by bind.
// ----------------------------------------------------------------------------
module xld_checker
  import xld_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [7:0]          out_byte_a,
  input logic [7:0]          out_byte_b,
  input logic [7:0]          out_byte_c,
  input logic [1:0]          out_byte_count,
  input logic                out_line_done,
  input logic [STATUS_W-1:0] out_line_status
);

  // status only on the line-end request, and never pending there
  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_done == (out_line_status != ST_PENDING)))
    else $error("line status does not match line_done");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_status <= ST_TERMTRAIL))
    else $error("line status out of range");

  // bytes past the count are zero
  a_unused_bytes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_byte_count == 2'd3 || out_byte_c == 8'd0) &&
                   (out_byte_count >= 2'd2 || out_byte_b == 8'd0) &&
                   (out_byte_count >= 2'd1 || out_byte_a == 8'd0)))
    else $error("byte beyond byte_count is not zero");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_a) &&
      $stable(out_byte_count) && $stable(out_line_status))
    else $error("stalled result changed");

  // input is held off only behind a stalled result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

endmodule

bind xxencode_line_decoder xld_checker u_xld_checker (.*);

// ===== tb/tb_xxencode_line_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_xxencode_line_decoder
// Self-checking bench for the line decoder. A behavioral decoder tracks the
// line state and predicts one result per accepted request; every result is
// checked in order. A directed table comes first, then random lines (mostly
// well-formed, some broken or pure noise) under three idling patterns.
// ----------------------------------------------------------------------------
module tb_xxencode_line_decoder;
  import xld_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 500;
  localparam string ALPHA =
    "+-0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  typedef struct packed {
    phase_t              phase;
    logic [LEN_W-1:0]    decl;
    logic [LEN_W-1:0]    taken;
    logic [HOLD_W-1:0]   hold;
    logic [LEN_W-1:0]    emitted;
    logic [STATUS_W-1:0] err;
  } line_state_t;

  localparam line_state_t LINE_IDLE = '{phase: PH_LEN, default: '0};

  // directed row: request fields, then the result where it is typed in
  typedef struct packed {
    logic [7:0]          code;
    logic                pres;
    logic                lend;
    logic                typed;
    logic [7:0]          byte_a;
    logic [1:0]          cnt;
    logic [STATUS_W-1:0] status;
  } dir_row_t;

  localparam int DIR_N = 30;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{8'h00,     1'b0, 1'b1, 1'b1, 8'h00, 2'd0, ST_EMPTY},     // bare end, nothing on line
    '{8'h5A,     1'b0, 1'b0, 1'b1, 8'h00, 2'd0, ST_PENDING},   // ignored request
    '{CH_SPACE,  1'b1, 1'b1, 1'b1, 8'h00, 2'd0, ST_TERM},
    '{CH_PLUS,   1'b1, 1'b0, 1'b1, 8'h00, 2'd0, ST_PENDING},   // zero length
    '{CH_TAB,    1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{8'h78,     1'b1, 1'b1, 1'b1, 8'h00, 2'd0, ST_TERMTRAIL},
    '{8'hFF,     1'b1, 1'b1, 1'b1, 8'h00, 2'd0, ST_BADCHAR},   // bad length char
    '{8'h7A,     1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},   // length 63
    '{8'h00,     1'b1, 1'b1, 1'b1, 8'h00, 2'd0, ST_TOOMANY},   // rest of line ignored
    '{8'h69,     1'b1, 1'b1, 1'b1, 8'h00, 2'd0, ST_TOOMANY},   // length 46
    '{8'h68,     1'b1, 1'b1, 1'b1, 8'h00, 2'd0, ST_TRUNC},     // length 45, ends at once
    '{CH_MINUS,  1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},   // length 1
    '{8'h7A,     1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{8'h7A,     1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{8'h7A,     1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{8'h7A,     1'b1, 1'b0, 1'b1, 8'hFF, 2'd1, ST_PENDING},
    '{8'h00,     1'b0, 1'b1, 1'b1, 8'h00, 2'd0, ST_PAYLOAD},
    '{CH_MINUS,  1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{8'h21,     1'b1, 1'b1, 1'b1, 8'h00, 2'd0, ST_TRUNC},     // truncation beats bad char
    '{CH_MINUS,  1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{8'h21,     1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{CH_PLUS,   1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{CH_PLUS,   1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{CH_PLUS,   1'b1, 1'b1, 1'b1, 8'h00, 2'd0, ST_BADCHAR},   // group done, no bytes
    '{CH_MINUS,  1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{CH_PLUS,   1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{CH_PLUS,   1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{CH_PLUS,   1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{CH_PLUS,   1'b1, 1'b0, 1'b0, 8'h00, 2'd0, ST_PENDING},
    '{8'h51,     1'b1, 1'b1, 1'b1, 8'h00, 2'd0, ST_TRAILING}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CHAR_W-1:0]   in_char_code;
  logic                in_char_present;
  logic                in_line_end;
  logic                out_valid;
  logic                out_stall;
  logic [7:0]          out_byte_a;
  logic [7:0]          out_byte_b;
  logic [7:0]          out_byte_c;
  logic [1:0]          out_byte_count;
  logic                out_line_done;
  logic [STATUS_W-1:0] out_line_status;

  // typed-in result travels with the request it belongs to
  logic                req_typed;
  xld_result_t         req_want;

  line_state_t         line_st;
  xld_result_t         line_results_q[$];
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  logic                hold_req;
  logic                hold_done = 1'b0;
  int unsigned         hold_left = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         fails = 0;
  int unsigned         n_chars_sent = 0;
  int unsigned         n_results = 0;
  int unsigned         n_lines = 0;
  int unsigned         n_clean = 0;
  int unsigned         n_bytes = 0;

  xxencode_line_decoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_char_present (in_char_present),
    .in_line_end     (in_line_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_a      (out_byte_a),
    .out_byte_b      (out_byte_b),
    .out_byte_c      (out_byte_c),
    .out_byte_count  (out_byte_count),
    .out_line_done   (out_line_done),
    .out_line_status (out_line_status)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  function automatic int alpha_val(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (ALPHA[i] == c) return i;
    end
    return 64;
  endfunction

  function automatic logic [7:0] sym(input int v);
    return ALPHA[v];
  endfunction

  function automatic xld_item_t item_of(input logic [7:0] c, input logic p, input logic e);
    xld_item_t it;
    it.char_code    = c;
    it.char_present = p;
    it.line_end     = e;
    return it;
  endfunction

  // advances line_st by one request and returns the result it produces
  function automatic xld_result_t xx_decode(input xld_item_t it);
    xld_result_t r;
    int          v;
    int          left;
    int          take;
    logic [5:0]  v6;
    logic [23:0] grp;
    logic        blank;
    r = '0;
    blank = (it.char_code == CH_SPACE) || (it.char_code == CH_TAB);
    if (it.char_present) begin
      v = alpha_val(it.char_code);
      case (line_st.phase)
        PH_LEN: begin
          if (it.char_code == CH_SPACE || v == 0) begin
            line_st.phase = PH_TERM;
          end else if (v == 64) begin
            line_st.phase = PH_DEAD;
            line_st.err   = ST_BADCHAR;
          end else if (v > int'(MAX_LINE_BYTES)) begin
            line_st.phase = PH_DEAD;
            line_st.err   = ST_TOOMANY;
          end else begin
            line_st.phase   = PH_PAY;
            line_st.decl    = LEN_W'(v);
            line_st.taken   = '0;
            line_st.hold    = '0;
            line_st.emitted = '0;
          end
        end
        PH_PAY: begin
          // a bad payload char still fills its slot, as zero
          if (v == 64) begin
            line_st.err = ST_BADCHAR;
            v = 0;
          end
          v6 = v[5:0];
          if (line_st.taken < 3) begin
            line_st.hold  = {line_st.hold[11:0], v6};
            line_st.taken = line_st.taken + 1'b1;
          end else begin
            grp  = {line_st.hold, v6};
            left = int'(line_st.decl) - int'(line_st.emitted);
            take = (left < 3) ? left : 3;
            if (line_st.err == '0) begin
              r.byte_a     = grp[23:16];
              r.byte_b     = (take > 1) ? grp[15:8] : 8'h00;
              r.byte_c     = (take > 2) ? grp[7:0] : 8'h00;
              r.byte_count = 2'(take);
            end
            line_st.emitted = LEN_W'(int'(line_st.emitted) + take);
            line_st.taken   = '0;
            line_st.hold    = '0;
            if (line_st.emitted >= line_st.decl) line_st.phase = PH_TAIL;
          end
        end
        PH_TAIL: if (!blank) line_st.err = ST_TRAILING;
        PH_TERM: if (!blank) line_st.err = ST_TERMTRAIL;
        default: ;
      endcase
    end
    if (it.line_end) begin
      r.line_done = 1'b1;
      case (line_st.phase)
        PH_LEN:  r.line_status = ST_EMPTY;
        PH_PAY:  r.line_status = ST_TRUNC;
        PH_TAIL: r.line_status = (line_st.err != '0) ? line_st.err : ST_PAYLOAD;
        PH_TERM: r.line_status = (line_st.err != '0) ? line_st.err : ST_TERM;
        default: r.line_status = line_st.err;
      endcase
      line_st = LINE_IDLE;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // input side: every accepted request gets its expected result queued
  always @(posedge clk) begin : mon_in
    xld_result_t pred;
    if (!rst_n) begin
      line_st = LINE_IDLE;
    end else if (in_valid && !in_stall) begin
      pred = xx_decode(item_of(in_char_code, in_char_present, in_line_end));
      if (req_typed) pred = req_want;
      line_results_q.insert(line_results_q.size(), pred);
    end
  end

  always @(posedge clk) begin : mon_out
    xld_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (line_results_q.size() == 0) begin
        $error("result with nothing expected: status %0d count %0d",
               out_line_status, out_byte_count);
        fails++;
      end else begin
        want = line_results_q.pop_front();
        check_field("byte_a", want.byte_a, out_byte_a);
        check_field("byte_b", want.byte_b, out_byte_b);
        check_field("byte_c", want.byte_c, out_byte_c);
        check_field("byte_count", 8'(want.byte_count), 8'(out_byte_count));
        check_field("line_done", 8'(want.line_done), 8'(out_line_done));
        check_field("line_status", 8'(want.line_status), 8'(out_line_status));
        n_bytes += want.byte_count;
        if (want.line_done) begin
          n_lines++;
          if (want.line_status == ST_PAYLOAD) n_clean++;
        end
      end
    end
  end

  // result side stall, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic offer(input xld_item_t it, input logic typed, input xld_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_char_code    <= it.char_code;
    in_char_present <= it.char_present;
    in_line_end     <= it.line_end;
    req_typed       <= typed;
    req_want        <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // one edge first so the last accepted request is already queued
  task automatic wait_drained();
    @(posedge clk);
    while (line_results_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] bad_code();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (alpha_val(c) != 64);
    return c;
  endfunction

  function automatic logic [7:0] blank_code();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  // one random line: mostly well-formed payload, plus terminators and junk
  task automatic send_line();
    xld_item_t q[$];
    int        kind;
    int        len;
    int        nchar;
    int        bad_at;
    int        cut;
    kind = $urandom_range(99);
    if (kind < 60) begin
      len = ($urandom_range(9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 45);
      if ($urandom_range(19) == 0) len = 45;
      q.insert(q.size(), item_of(sym(len), 1'b1, 1'b0));
      nchar  = ((len + 2) / 3) * 4;
      bad_at = ($urandom_range(9) == 0) ? $urandom_range(nchar - 1) : -1;
      for (int i = 0; i < nchar; i++) begin
        q.insert(q.size(), item_of((i == bad_at) ? bad_code() : sym($urandom_range(63)),
                                   1'b1, 1'b0));
      end
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(1, q.size() - 1);
        while (q.size() > cut) q.delete(q.size() - 1);
      end else begin
        repeat ($urandom_range(3)) q.insert(q.size(), item_of(blank_code(), 1'b1, 1'b0));
        if ($urandom_range(9) == 0) q.insert(q.size(), item_of(bad_code(), 1'b1, 1'b0));
      end
    end else if (kind < 72) begin
      q.insert(q.size(), item_of($urandom_range(1) ? CH_SPACE : CH_PLUS, 1'b1, 1'b0));
      repeat ($urandom_range(3)) q.insert(q.size(), item_of(blank_code(), 1'b1, 1'b0));
      if ($urandom_range(3) == 0) begin
        q.insert(q.size(), item_of(8'($urandom_range(255)), 1'b1, 1'b0));
      end
    end else if (kind < 78) begin
      // empty line: only the line end below
    end else if (kind < 88) begin
      q.insert(q.size(), item_of($urandom_range(1) ? sym($urandom_range(46, 63)) : bad_code(),
                                 1'b1, 1'b0));
      repeat ($urandom_range(4)) begin
        q.insert(q.size(), item_of(8'($urandom_range(255)), 1'b1, 1'b0));
      end
    end else begin
      repeat ($urandom_range(8)) begin
        q.insert(q.size(), item_of(8'($urandom_range(255)), 1'b1, 1'b0));
      end
    end
    if (q.size() != 0 && $urandom_range(1)) begin
      q[q.size() - 1].line_end = 1'b1;
    end else begin
      q.insert(q.size(), item_of(8'($urandom_range(255)), 1'b0, 1'b1));
    end
    foreach (q[i]) begin
      if ($urandom_range(24) == 0) begin
        offer(item_of(8'($urandom_range(255)), 1'b0, 1'b0), 1'b0, '0);
      end
      offer(q[i], 1'b0, '0);
      n_chars_sent++;
    end
  endtask

  initial begin
    xld_result_t want;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_char_code    = '0;
    in_char_present = 1'b0;
    in_line_end     = 1'b0;
    out_stall       = 1'b0;
    req_typed       = 1'b0;
    req_want        = '0;
    hold_req        = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TAB[i]) begin
      want             = '0;
      want.byte_a      = DIR_TAB[i].byte_a;
      want.byte_count  = DIR_TAB[i].cnt;
      want.line_done   = DIR_TAB[i].lend;
      want.line_status = DIR_TAB[i].status;
      offer(item_of(DIR_TAB[i].code, DIR_TAB[i].pres, DIR_TAB[i].lend),
            DIR_TAB[i].typed, want);
    end
    in_valid <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct <= (ph == 0) ? 31 : (ph == 1) ? 70 : 0;
      recv_idle_pct <= (ph == 0) ? 70 : (ph == 1) ? 31 : 0;
      // long result hold-off while requests keep coming
      if (ph == 2) hold_req <= 1'b1;
      while (n_chars_sent < (ph + 1) * PHASE_ITEMS) send_line();
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (6) @(posedge clk);
    $display("run covered %0d results over %0d lines, %0d of them clean payload lines",
             n_results, n_lines, n_clean);
    $display("decoded bytes seen: %0d, mismatches: %0d", n_bytes, fails);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/xld_pkg.sv
sv/xld_line_ctl.sv
sv/xxencode_line_decoder.sv
sv/xld_checker.sv
tb/tb_xxencode_line_decoder.sv
